/* design/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, operation codes and result type of the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FRAC_BITS = 8;
	localparam int WORD      = 32;
	// dividend magnitude |a| << FRAC_BITS, one quotient bit per divider stage
	localparam int DIV_BITS  = WORD + FRAC_BITS;
	// stages: input, prepare, DIV_BITS divider steps, output
	localparam int LAT       = DIV_BITS + 3;

	localparam int IN_BYTES  = 16;
	localparam int OUT_BYTES = 13;

	typedef enum logic [4:0] {
		OP_ADD     = 5'd0,
		OP_SUB     = 5'd1,
		OP_MUL     = 5'd2,
		OP_DIV     = 5'd3,
		OP_GT      = 5'd4,
		OP_LT      = 5'd5,
		OP_GE      = 5'd6,
		OP_LE      = 5'd7,
		OP_EQ      = 5'd8,
		OP_NE      = 5'd9,
		OP_MIN     = 5'd10,
		OP_MAX     = 5'd11,
		OP_INC     = 5'd12,
		OP_DEC     = 5'd13,
		OP_INT2FIX = 5'd14,
		OP_FIX2INT = 5'd15,
		OP_FLT2FIX = 5'd16,
		OP_FIX2FLT = 5'd17
	} op_t;

	typedef struct packed {
		logic        use_div;
		logic        dz;
		logic [31:0] flt;
		logic [31:0] whole;
		logic        cmp;
		logic [31:0] raw;
	} res_t;

endpackage

/* design/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu
// Pipelined signed 32-bit fixed-point ALU with a bit-per-stage divider.
// ----------------------------------------------------------------------------
// usage:
//   - s_axis carries one operation per transaction; tuser is the operation
//     code, tdata holds operand_a, operand_b, whole_number and float_bits
//   - m_axis returns exactly one result transaction per input, in order
//   - every operation takes the same path through the pipeline; the
//     restoring divider, one quotient bit per stage, sets its depth
//   - throughput is one transaction per cycle unless the receiver stalls: a new
//     item can enter every cycle while earlier ones move down the pipeline
//   - multiply uses one 32x32 multiplier, registered before the shift
//   - fixed to float finds the leading one in one stage and rounds in the next
//   - the whole pipeline advances together; when the receiver stalls with a
//     result waiting, every stage holds and s_axis_tready drops, so nothing
//     is lost or repeated; bubbles move forward and free the input
//   - reset clears the stage valid bits only; the pipeline comes up empty
//   - unknown operation codes return a result with all fields zero
// ----------------------------------------------------------------------------
module fixed_point_alu (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// operand_a, operand_b, whole_number, float_bits (from bit 0 up)
	input  logic [fpa_pkg::IN_BYTES*8-1:0]     s_axis_tdata,
	// operation
	input  logic [4:0]                         s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// raw_result, compare_true, whole_result, float_result, divide_by_zero, zero pad
	output logic [fpa_pkg::OUT_BYTES*8-1:0]    m_axis_tdata
);
	import fpa_pkg::*;

	// pipeline advance for every stage at once
	logic en;
	logic vld_s [0:LAT-1];

	assign en            = !vld_s[LAT-1] || m_axis_tready;
	assign s_axis_tready = en;
	assign m_axis_tvalid = vld_s[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= s_axis_tvalid;
			for (int i = 1; i < LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	// ---------------- stage 1: input capture ----------------
	logic [4:0]         op_s1;
	logic signed [31:0] a_s1, b_s1, w_s1;
	logic [31:0]        f_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= s_axis_tuser;
			a_s1  <= s_axis_tdata[31:0];
			b_s1  <= s_axis_tdata[63:32];
			w_s1  <= s_axis_tdata[95:64];
			f_s1  <= s_axis_tdata[127:96];
		end
	end

	// ---------------- stage 2: simple ops, multiply, prepare ----------------
	res_t               base_c;
	logic signed [63:0] prod_c;
	logic [63:0]        fmag_c;
	logic [23:0]        fmant_c;
	logic signed [9:0]  fsh_c;
	logic [9:0]         fr_c;
	logic [31:0]        xmag_c;

	always_comb begin
		base_c = '0;
		case (op_s1)
			OP_ADD:     base_c.raw = a_s1 + b_s1;
			OP_SUB:     base_c.raw = a_s1 - b_s1;
			OP_DIV: begin
				if (b_s1 == 32'sd0) begin
					base_c.raw = a_s1;
					base_c.dz  = 1'b1;
				end else begin
					base_c.use_div = 1'b1;
				end
			end
			OP_GT:      base_c.cmp = a_s1 >  b_s1;
			OP_LT:      base_c.cmp = a_s1 <  b_s1;
			OP_GE:      base_c.cmp = a_s1 >= b_s1;
			OP_LE:      base_c.cmp = a_s1 <= b_s1;
			OP_EQ:      base_c.cmp = a_s1 == b_s1;
			OP_NE:      base_c.cmp = a_s1 != b_s1;
			OP_MIN:     base_c.raw = (a_s1 < b_s1) ? a_s1 : b_s1;
			OP_MAX:     base_c.raw = (a_s1 > b_s1) ? a_s1 : b_s1;
			OP_INC:     base_c.raw = a_s1 + 32'sd1;
			OP_DEC:     base_c.raw = a_s1 - 32'sd1;
			OP_INT2FIX: base_c.raw = w_s1 << FRAC_BITS;
			OP_FIX2INT: base_c.whole = a_s1 >>> FRAC_BITS;
			default:    base_c = '0;
		endcase

		prod_c = a_s1 * b_s1;

		// float to fixed: align mantissa, round half away from zero
		fmant_c = (f_s1[30:23] == 8'd0) ? {1'b0, f_s1[22:0]} : {1'b1, f_s1[22:0]};
		fsh_c   = ((f_s1[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, f_s1[30:23]}))
		          - 10'sd150 + 10'(FRAC_BITS);
		fr_c    = 10'(-fsh_c);
		if (fsh_c >= 10'sd0) begin
			if (fsh_c > 10'sd40) fmag_c = 64'hFF_FFFF_FFFF;
			else                 fmag_c = {40'd0, fmant_c} << fsh_c[5:0];
		end else begin
			if (fr_c > 10'd25) fmag_c = '0;
			else fmag_c = ({40'd0, fmant_c} + (64'd1 << (fr_c[4:0] - 5'd1))) >> fr_c[4:0];
		end

		xmag_c = a_s1[31] ? 32'(-a_s1) : 32'(a_s1);
	end

	res_t               base_s2;
	logic               is_mul_s2, is_f2x_s2, is_x2f_s2;
	logic signed [63:0] prod_s2;
	logic [63:0]        fmag_s2;
	logic               fneg_s2, fspec_s2, fnan_s2;
	logic [31:0]        xmag_s2;
	logic               xsign_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			base_s2   <= base_c;
			is_mul_s2 <= (op_s1 == OP_MUL);
			is_f2x_s2 <= (op_s1 == OP_FLT2FIX);
			is_x2f_s2 <= (op_s1 == OP_FIX2FLT);
			prod_s2   <= prod_c;
			fmag_s2   <= fmag_c;
			fneg_s2   <= f_s1[31];
			fspec_s2  <= (f_s1[30:23] == 8'hFF);
			fnan_s2   <= (f_s1[22:0] != 23'd0);
			xmag_s2   <= xmag_c;
			xsign_s2  <= a_s1[31];
		end
	end

	// ---------------- stage 3: multiply shift, saturation, leading one ----------------
	res_t               mid_c;
	logic signed [63:0] pshift_c;
	logic [4:0]         xp_c;

	always_comb begin
		mid_c    = base_s2;
		pshift_c = prod_s2 >>> FRAC_BITS;
		if (is_mul_s2) mid_c.raw = pshift_c[31:0];
		if (is_f2x_s2) begin
			if (fspec_s2) begin
				if (fnan_s2)      mid_c.raw = 32'h0000_0000;
				else if (fneg_s2) mid_c.raw = 32'h8000_0000;
				else              mid_c.raw = 32'h7FFF_FFFF;
			end else if (fneg_s2) begin
				if (fmag_s2 >= 64'h8000_0000) mid_c.raw = 32'h8000_0000;
				else                          mid_c.raw = 32'(-fmag_s2[31:0]);
			end else begin
				if (fmag_s2 > 64'h7FFF_FFFF) mid_c.raw = 32'h7FFF_FFFF;
				else                         mid_c.raw = fmag_s2[31:0];
			end
		end
		xp_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (xmag_s2[i]) xp_c = 5'(i);
		end
	end

	res_t        mid_s3;
	logic        is_x2f_s3, xsign_s3;
	logic [31:0] xmag_s3;
	logic [4:0]  xp_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			mid_s3    <= mid_c;
			is_x2f_s3 <= is_x2f_s2;
			xsign_s3  <= xsign_s2;
			xmag_s3   <= xmag_s2;
			xp_s3     <= xp_c;
		end
	end

	// ---------------- stage 4: fixed to float rounding and packing ----------------
	res_t        fin_c;
	logic [31:0] xm_c, xrem_c, xhalf_c;
	logic [4:0]  xr_c;
	logic [5:0]  xpe_c;
	logic [7:0]  xexp_c;

	always_comb begin
		fin_c   = mid_s3;
		xpe_c   = {1'b0, xp_s3};
		xr_c    = xp_s3 - 5'd23;
		xrem_c  = '0;
		xhalf_c = '0;
		if (xp_s3 <= 5'd23) begin
			xm_c = xmag_s3 << (5'd23 - xp_s3);
		end else begin
			xrem_c  = xmag_s3 & ((32'd1 << xr_c) - 32'd1);
			xhalf_c = 32'd1 << (xr_c - 5'd1);
			xm_c    = xmag_s3 >> xr_c;
			if (xrem_c > xhalf_c || (xrem_c == xhalf_c && xm_c[0])) xm_c = xm_c + 32'd1;
			if (xm_c == 32'h0100_0000) begin
				xm_c  = xm_c >> 1;
				xpe_c = xpe_c + 6'd1;
			end
		end
		// biased exponent, scaled down by the fraction bits
		xexp_c = 8'(xpe_c) + 8'd127 - 8'(FRAC_BITS);
		if (is_x2f_s3) begin
			if (xmag_s3 == 32'd0) fin_c.flt = '0;
			else                  fin_c.flt = {xsign_s3, xexp_c, xm_c[22:0]};
		end
	end

	// delay line for non-divide results, aligned with the divider
	res_t mres_s [0:DIV_BITS-2];

	always_ff @(posedge clk) begin
		if (en) begin
			mres_s[0] <= fin_c;
			for (int i = 1; i < DIV_BITS - 1; i++) mres_s[i] <= mres_s[i-1];
		end
	end

	// ---------------- divider: one restoring step per stage ----------------
	// remainder in the upper word, dividend shifting out / quotient in below
	logic [WORD+DIV_BITS-1:0] dv_rq_s  [0:DIV_BITS];
	logic [WORD-1:0]          dv_m_s   [0:DIV_BITS];
	logic                     dv_neg_s [0:DIV_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rq_s[0]  <= {32'd0, xmag_c, {FRAC_BITS{1'b0}}};
			dv_m_s[0]   <= b_s1[31] ? 32'(-b_s1) : 32'(b_s1);
			dv_neg_s[0] <= a_s1[31] ^ b_s1[31];
		end
	end

	for (genvar j = 0; j < DIV_BITS; j++) begin : g_div
		logic [WORD:0]    cand;
		logic [WORD:0]    diff;
		logic             take;
		logic [DIV_BITS-1:0] dq;

		assign dq   = dv_rq_s[j][DIV_BITS-1:0];
		assign cand = {dv_rq_s[j][WORD+DIV_BITS-1:DIV_BITS], dq[DIV_BITS-1]};
		assign diff = cand - {1'b0, dv_m_s[j]};
		assign take = cand >= {1'b0, dv_m_s[j]};

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rq_s[j+1]  <= take ? {diff[WORD-1:0], dq[DIV_BITS-2:0], 1'b1}
				                      : {cand[WORD-1:0], dq[DIV_BITS-2:0], 1'b0};
				dv_m_s[j+1]   <= dv_m_s[j];
				dv_neg_s[j+1] <= dv_neg_s[j];
			end
		end
	end

	// ---------------- output stage ----------------
	res_t        last_c;
	logic [31:0] q_c;
	res_t        out_s;

	always_comb begin
		last_c = mres_s[DIV_BITS-2];
		q_c    = dv_rq_s[DIV_BITS][31:0];
		if (last_c.use_div) last_c.raw = dv_neg_s[DIV_BITS] ? 32'(-q_c) : q_c;
	end

	always_ff @(posedge clk) begin
		if (en) out_s <= last_c;
	end

	assign m_axis_tdata = {6'd0, out_s.dz, out_s.flt, out_s.whole, out_s.cmp, out_s.raw};

	// ---------------- assertions ----------------
	a_drain_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[LAT-1] |-> s_axis_tready)
		else $error("input blocked with empty output stage");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> vld_s[0])
		else $error("accepted transaction not captured");

	a_dz_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_s.dz |-> !out_s.cmp && out_s.whole == '0 && out_s.flt == '0)
		else $error("divide by zero result carries other fields");

	a_cmp_alone: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_s.cmp |-> out_s.raw == '0 && out_s.flt == '0 && !out_s.dz)
		else $error("compare result carries other fields");

endmodule

/* tb/fixed_point_alu_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu_tb
// Self-checking bench: a directed table then random operations are streamed
// into the ALU with random gaps and a long receiver stall, and every result
// transaction is compared field by field with a table entry or a behavioral predictor.
// ----------------------------------------------------------------------------
module fixed_point_alu_tb;
	import fpa_pkg::*;

	localparam int N_RANDOM  = 900;
	localparam int WDOG_MAX  = 2000;

	typedef struct packed {
		logic [31:0] flt;
		logic [31:0] whole;
		logic [31:0] b;
		logic [31:0] a;
	} alu_in_t;

	typedef struct {
		logic [4:0]  op;
		alu_in_t     d;
		logic        known;
		logic [OUT_BYTES*8-1:0] res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_BYTES*8-1:0] s_axis_tdata = '0;
	logic [4:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_BYTES*8-1:0] m_axis_tdata;

	// queue of result words still to arrive, oldest first
	logic [OUT_BYTES*8-1:0] pending_results[$];
	row_t  dir_rows[$];
	int    mismatches = 0;
	int    idle_cycles = 0;
	int    n_sent = 0;
	bit    stim_done = 1'b0;
	bit    hold_rx = 1'b0;

	always #2 clk = ~clk;

	fixed_point_alu i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	function automatic logic [31:0] flt_to_fix(logic [31:0] bits);
		logic        neg;
		logic [7:0]  ex;
		logic [22:0] fr;
		logic [63:0] mant, mag;
		int          s;
		neg = bits[31]; ex = bits[30:23]; fr = bits[22:0];
		if (ex == 8'hff) begin
			if (fr != 0) return 32'h0;
			return neg ? 32'h8000_0000 : 32'h7fff_ffff;
		end
		if (ex == 0) begin
			mant = {41'd0, fr};
			s = 1 - 150 + FRAC_BITS;
		end else begin
			mant = {40'd0, 1'b1, fr};
			s = int'(ex) - 150 + FRAC_BITS;
		end
		if (s >= 0) mag = (s > 40) ? 64'hff_ffff_ffff : mant << s;
		else if (-s > 25) mag = 0;
		else mag = (mant + (64'd1 << (-s - 1))) >> (-s);
		if (neg) return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'h0 - mag[31:0];
		return (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
	endfunction

	function automatic logic [31:0] fix_to_flt(logic [31:0] a);
		logic [31:0] mag, mant, rem, half;
		int p, r;
		mag = a[31] ? 32'h0 - a : a;
		if (mag == 0) return 32'h0;
		p = 31;
		while (!mag[p]) p--;
		if (p <= 23) mant = mag << (23 - p);
		else begin
			r = p - 23;
			rem = mag & ((32'd1 << r) - 1);
			half = 32'd1 << (r - 1);
			mant = mag >> r;
			if (rem > half || (rem == half && mant[0])) mant++;
			if (mant == 32'h100_0000) begin
				mant >>= 1;
				p++;
			end
		end
		return {a[31], 8'(p - FRAC_BITS + 127), mant[22:0]};
	endfunction

	// expected result word for one operation
	function automatic logic [OUT_BYTES*8-1:0] alu_predict(logic [4:0] op, alu_in_t d);
		logic signed [31:0] a, b;
		logic signed [63:0] wide;
		logic [31:0] raw, whole, flt;
		logic cmp, dz;
		a = d.a; b = d.b;
		raw = 0; whole = 0; flt = 0; cmp = 0; dz = 0;
		case (op)
			OP_ADD: raw = a + b;
			OP_SUB: raw = a - b;
			OP_MUL: begin
				wide = 64'(a) * 64'(b);
				wide = wide >>> FRAC_BITS;
				raw = wide[31:0];
			end
			OP_DIV: begin
				if (b == 0) begin
					raw = a;
					dz = 1;
				end else begin
					wide = (64'(a) <<< FRAC_BITS) / 64'(b);
					raw = wide[31:0];
				end
			end
			OP_GT: cmp = a > b;
			OP_LT: cmp = a < b;
			OP_GE: cmp = a >= b;
			OP_LE: cmp = a <= b;
			OP_EQ: cmp = a == b;
			OP_NE: cmp = a != b;
			OP_MIN: raw = (a < b) ? a : b;
			OP_MAX: raw = (a > b) ? a : b;
			OP_INC: raw = a + 1;
			OP_DEC: raw = a - 1;
			OP_INT2FIX: raw = d.whole << FRAC_BITS;
			OP_FIX2INT: whole = a >>> FRAC_BITS;
			OP_FLT2FIX: raw = flt_to_fix(d.flt);
			OP_FIX2FLT: flt = fix_to_flt(d.a);
			default: ;
		endcase
		return {6'd0, dz, flt, whole, cmp, raw};
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000);
			3: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_row(logic [4:0] op, logic [31:0] a, logic [31:0] b,
			logic [31:0] w, logic [31:0] f, logic known,
			logic [OUT_BYTES*8-1:0] res);
		row_t r;
		r.op = op; r.d = {f, w, b, a}; r.known = known; r.res = res;
		dir_rows.push_back(r);
	endtask

	// one transaction on the slave side, with a random gap first
	task automatic send_item(logic [4:0] op, alu_in_t d, logic [OUT_BYTES*8-1:0] res);
		int gap;
		gap = $urandom_range(0, 10);
		if ($urandom_range(0, 3) == 0) gap = 0;
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= op;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		pending_results.push_back(res);
		n_sent++;
	endtask

	// sender
	initial begin
		row_t r;
		alu_in_t d;
		logic [4:0] op;
		int k;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);
		// extremes, division by zero, unknown code, float specials
		add_row(OP_ADD, 32'h7fff_ffff, 32'd1, 0, 0, 1, {71'd0, 32'h8000_0000});
		add_row(OP_SUB, 32'h8000_0000, 32'd1, 0, 0, 1, {71'd0, 32'h7fff_ffff});
		add_row(OP_MUL, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0);
		add_row(OP_MUL, 32'hffff_ffff, 32'd1, 0, 0, 1, {71'd0, 32'hffff_ffff});
		add_row(OP_DIV, 32'h1234_5678, 32'd0, 0, 0, 1, {6'd1, 65'd0, 32'h1234_5678});
		add_row(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 0, 0, 0, 0);
		add_row(OP_DIV, 32'hffff_ff00, 32'd3, 0, 0, 0, 0);
		add_row(OP_GT, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 1, {71'd1, 32'd0});
		add_row(OP_LT, 32'h7fff_ffff, 32'h8000_0000, 0, 0, 1, 0);
		add_row(OP_GE, 32'd5, 32'd5, 0, 0, 1, {71'd1, 32'd0});
		add_row(OP_LE, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 1, {71'd1, 32'd0});
		add_row(OP_EQ, 32'hffff_ffff, 32'hffff_ffff, 0, 0, 1, {71'd1, 32'd0});
		add_row(OP_NE, 32'd0, 32'd0, 0, 0, 1, 0);
		add_row(OP_MIN, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 1, {71'd0, 32'h8000_0000});
		add_row(OP_MAX, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 1, {71'd0, 32'h7fff_ffff});
		add_row(OP_INC, 32'h7fff_ffff, 0, 0, 0, 1, {71'd0, 32'h8000_0000});
		add_row(OP_DEC, 32'h8000_0000, 0, 0, 0, 1, {71'd0, 32'h7fff_ffff});
		add_row(OP_INT2FIX, 0, 0, 32'hffff_ffff, 0, 1, {71'd0, 32'hffff_ff00});
		add_row(OP_FIX2INT, 32'h8000_0000, 0, 0, 0, 1, {39'd0, 32'hff80_0000, 33'd0});
		add_row(OP_FLT2FIX, 0, 0, 0, 32'h7f80_0000, 1, {71'd0, 32'h7fff_ffff});
		add_row(OP_FLT2FIX, 0, 0, 0, 32'hff80_0000, 1, {71'd0, 32'h8000_0000});
		add_row(OP_FLT2FIX, 0, 0, 0, 32'h7fc0_0001, 1, 0);
		add_row(OP_FLT2FIX, 0, 0, 0, 32'hbfc0_0000 - 32'h0300_0000, 0, 0);
		add_row(OP_FIX2FLT, 32'd0, 0, 0, 0, 1, 0);
		add_row(OP_FIX2FLT, 32'h8000_0000, 0, 0, 0, 0, 0);
		add_row(5'd31, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 0);
		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			send_item(r.op, r.d, r.known ? r.res : alu_predict(r.op, r.d));
		end
		for (k = 0; k < N_RANDOM; k++) begin
			op = ($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
				: 5'($urandom_range(OP_ADD, OP_FIX2FLT));
			d.a = rand_word();
			d.b = ($urandom_range(0, 9) == 0) ? 32'd0 : rand_word();
			if ($urandom_range(0, 7) == 0) d.b = d.a;
			d.whole = rand_word();
			// floats spread over exponents so rounding and saturation both appear
			d.flt = {1'($urandom), 8'($urandom_range(0, 255)), 23'($urandom)};
			if ($urandom_range(0, 1)) d.flt[30:23] = 8'($urandom_range(100, 160));
			send_item(op, d, alu_predict(op, d));
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		stim_done = 1'b1;
	end

	// long receiver hold-off during the random part, counted here so the pipeline fills
	initial begin
		wait (n_sent >= 300);
		hold_rx = 1'b1;
		repeat (200) @(posedge clk);
		hold_rx = 1'b0;
	end

	// receiver ready pattern, redrawn per result
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rx) begin
				m_axis_tready <= 1'b0;
			end else begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 10);
				if (gap > 0) begin
					m_axis_tready <= 1'b0;
					repeat (gap) @(negedge clk);
				end
				if (!hold_rx) begin
					m_axis_tready <= 1'b1;
					@(posedge clk);
					while (!m_axis_tvalid) @(posedge clk);
				end
			end
		end
	end

	// checker: compare each result transaction with the oldest expectation
	always @(posedge clk) begin
		logic [OUT_BYTES*8-1:0] exp_res;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", m_axis_tdata);
			end else begin
				exp_res = pending_results.pop_front();
				if (m_axis_tdata[31:0] !== exp_res[31:0]
						|| m_axis_tdata[32] !== exp_res[32]
						|| m_axis_tdata[64:33] !== exp_res[64:33]
						|| m_axis_tdata[96:65] !== exp_res[96:65]
						|| m_axis_tdata[97] !== exp_res[97]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: raw %h/%h cmp %b/%b whole %h/%h flt %h/%h dz %b/%b",
							exp_res[31:0], m_axis_tdata[31:0], exp_res[32], m_axis_tdata[32],
							exp_res[64:33], m_axis_tdata[64:33],
							exp_res[96:65], m_axis_tdata[96:65],
							exp_res[97], m_axis_tdata[97]);
				end
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		fork
			begin
				while (!(stim_done && pending_results.size() == 0)) @(posedge clk);
				repeat (LAT + 10) @(posedge clk);
			end
			begin
				wait (idle_cycles >= WDOG_MAX);
				$display("watchdog expired");
				mismatches++;
			end
		join_any
		if (mismatches == 0 && pending_results.size() == 0)
			$display("fixed_point_alu test passed");
		else
			$display("fixed_point_alu test failed");
		$finish;
	end

endmodule
